@@ rtl/dwc3_pkg.sv @@
// ----------------------------------------------------------------------------
// dwc3_pkg
// Types and constants shared by the 3x3 depthwise convolution block.
// ----------------------------------------------------------------------------
package dwc3_pkg;

    localparam int PIX_W       = 16;
    localparam int KROW_W      = 48;
    localparam int OUT_W       = 32;
    localparam int PROD_W      = 32;
    localparam int PSUM_W      = 34;
    localparam int SUM2_W      = 35;
    localparam int TOT_W       = 36;
    localparam int IMG_W_BITS  = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 3'd6;

    localparam logic signed [OUT_W-1:0] CLAMP_LOW_RST  = 32'sh8000_0000;
    localparam logic signed [OUT_W-1:0] CLAMP_HIGH_RST = 32'sh7FFF_FFFF;
    localparam logic [IMG_W_BITS-1:0]   IMG_WIDTH_RST  = 11'd1024;

    localparam int OQ_DEPTH = 16;
    localparam int OQ_SLACK = 9;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_PTR_W + 1;

    // index 0 top, 1 middle, 2 bottom
    typedef logic [2:0][PIX_W-1:0] t_col;

    typedef struct packed {
        logic valid;
        logic row_end;
        logic image_end;
        logic last_of_run;
    } t_tag;

    typedef struct packed {
        logic                    req_type;
        logic signed [PIX_W-1:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_value;
        logic                    row_end;
        logic                    image_end;
        logic                    last_of_run;
    } t_out_item;

endpackage

@@ rtl/dwc3_cell.sv @@
// ----------------------------------------------------------------------------
// dwc3_cell
// One window column: holds three pixels, passes them on at each shift and
// forms the weighted sum of its column over two register stages.
// ----------------------------------------------------------------------------
module dwc3_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_shift,
    input  dwc3_pkg::t_col                      i_col,
    input  dwc3_pkg::t_col                      i_wgt,
    output dwc3_pkg::t_col                      o_col,
    output logic signed [dwc3_pkg::PSUM_W-1:0]  o_psum
);
    import dwc3_pkg::*;

    t_col                     r_col;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [PROD_W-1:0] n_prod [3];
    logic signed [PSUM_W-1:0] r_psum;
    logic signed [PSUM_W-1:0] n_psum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = PROD_W'(signed'(r_col[k])) * PROD_W'(signed'(i_wgt[k]));
        end
        n_psum = PSUM_W'(r_prod[0]) + PSUM_W'(r_prod[1]) + PSUM_W'(r_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= n_prod[k];
        end
        r_psum <= n_psum;
    end

    assign o_col  = r_col;
    assign o_psum = r_psum;

endmodule

@@ rtl/dwc3_post.sv @@
// ----------------------------------------------------------------------------
// dwc3_post
// Adds the three column sums and the bias, then clamps to the low and high
// limits in that order.
// ----------------------------------------------------------------------------
module dwc3_post (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [dwc3_pkg::PSUM_W-1:0] i_psum [3],
    input  dwc3_pkg::t_tag                     i_tag,
    input  logic signed [dwc3_pkg::OUT_W-1:0]  i_bias,
    input  logic signed [dwc3_pkg::OUT_W-1:0]  i_clamp_lo,
    input  logic signed [dwc3_pkg::OUT_W-1:0]  i_clamp_hi,
    output logic                               o_push,
    output dwc3_pkg::t_out_item                o_item
);
    import dwc3_pkg::*;

    t_tag                     r_tag_a;
    t_tag                     r_tag_t;
    t_tag                     r_tag_l;
    logic signed [SUM2_W-1:0] r_s01;
    logic signed [SUM2_W-1:0] r_s2b;
    logic signed [TOT_W-1:0]  r_tot;
    logic signed [TOT_W-1:0]  r_lo;
    logic signed [SUM2_W-1:0] n_s01;
    logic signed [SUM2_W-1:0] n_s2b;
    logic signed [TOT_W-1:0]  n_tot;
    logic signed [TOT_W-1:0]  n_lo;
    logic signed [TOT_W-1:0]  lo_ext;
    logic signed [TOT_W-1:0]  hi_ext;
    logic signed [TOT_W-1:0]  clamped;

    always_comb begin
        n_s01   = SUM2_W'(i_psum[0]) + SUM2_W'(i_psum[1]);
        n_s2b   = SUM2_W'(i_psum[2]) + SUM2_W'(i_bias);
        n_tot   = TOT_W'(r_s01) + TOT_W'(r_s2b);
        lo_ext  = TOT_W'(i_clamp_lo);
        hi_ext  = TOT_W'(i_clamp_hi);
        n_lo    = (r_tot < lo_ext) ? lo_ext : r_tot;
        clamped = (r_lo > hi_ext) ? hi_ext : r_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_t <= '0;
            r_tag_l <= '0;
        end else begin
            r_tag_a <= i_tag;
            r_tag_t <= r_tag_a;
            r_tag_l <= r_tag_t;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s01 <= n_s01;
        r_s2b <= n_s2b;
        r_tot <= n_tot;
        r_lo  <= n_lo;
    end

    always_comb begin
        o_push             = r_tag_l.valid;
        o_item.out_value   = OUT_W'(clamped);
        o_item.row_end     = r_tag_l.row_end;
        o_item.image_end   = r_tag_l.image_end;
        o_item.last_of_run = r_tag_l.last_of_run;
    end

endmodule

@@ rtl/dwc3_fifo.sv @@
// ----------------------------------------------------------------------------
// dwc3_fifo
// Result queue between the arithmetic pipeline and the output channel.
// ----------------------------------------------------------------------------
module dwc3_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  dwc3_pkg::t_out_item              i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output dwc3_pkg::t_out_item              o_data,
    output logic [dwc3_pkg::OQ_CNT_W-1:0]    o_count
);
    import dwc3_pkg::*;

    t_out_item           r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_count;
    logic                pop;

    assign pop = (r_count != '0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OQ_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OQ_PTR_W'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + OQ_CNT_W'(1);
                2'b01:   r_count <= r_count - OQ_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

@@ rtl/depthwise_conv3x3_pad1_clamp.sv @@
// ----------------------------------------------------------------------------
// depthwise_conv3x3_pad1_clamp
// A result passes the input stage, window cells, post stage and queue.
// Throughput: one item per cycle while the queue has room; after a row's
// last item the input stalls while a closing zero column enters the window.
// Reset: synchronous, clears control, window and registers; line stores
// are not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module depthwise_conv3x3_pad1_clamp #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  dwc3_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output dwc3_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_wr_en,
    input  logic [dwc3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dwc3_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import dwc3_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;
    localparam logic [1:0] ROWS_FIRST  = 2'd0;
    localparam logic [1:0] ROWS_SECOND = 2'd1;
    localparam logic [1:0] ROWS_LATER  = 2'd2;

    logic [KROW_W-1:0]        r_k_top;
    logic [KROW_W-1:0]        r_k_mid;
    logic [KROW_W-1:0]        r_k_bot;
    logic signed [OUT_W-1:0]  r_bias;
    logic signed [OUT_W-1:0]  r_clamp_lo;
    logic signed [OUT_W-1:0]  r_clamp_hi;
    logic [IMG_W_BITS-1:0]    r_image_width;

    logic [CW-1:0]            r_col_cnt;
    logic [1:0]               r_rows;
    logic                     r_flush_pend;
    t_tag                     r_fl_tag;

    logic                     r_b_valid;
    logic                     r_b_item;
    t_tag                     r_b_tag;
    logic [CW-1:0]            r_b_idx;
    logic [PIX_W-1:0]         r_b_pix;
    logic [1:0]               r_b_rows;
    logic [PIX_W-1:0]         r_rd_above;
    logic [PIX_W-1:0]         r_rd_mid;

    logic [PIX_W-1:0]         line_above  [MAX_WIDTH];
    logic [PIX_W-1:0]         line_middle [MAX_WIDTH];

    t_tag                     r_tag_w;
    t_tag                     r_tag_p;
    t_tag                     r_tag_s;

    logic                     accept;
    logic                     pad;
    logic [PIX_W-1:0]         pix;
    logic [XW-1:0]            w_ext;
    logic [XW-1:0]            w_eff;
    logic [XW-1:0]            c_next;
    logic                     is_last;
    t_col                     newc;
    t_col                     wgt_l;
    t_col                     wgt_m;
    t_col                     wgt_r;
    t_col                     col_m;
    t_col                     col_r;
    logic signed [PSUM_W-1:0] psum [3];
    logic                     post_push;
    t_out_item                post_item;
    logic [OQ_CNT_W-1:0]      oq_count;

    always_comb begin
        accept = i_in_valid && !o_in_stall;
        pad    = i_in_data.req_type;
        pix    = pad ? '0 : i_in_data.pixel_value;
        w_ext  = XW'(r_image_width);
        if (w_ext == '0) begin
            w_eff = XW'(1);
        end else if (w_ext > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        c_next  = XW'(r_col_cnt) + XW'(1);
        is_last = (c_next >= w_eff);
    end

    assign o_in_stall = r_flush_pend ||
                        (oq_count >= OQ_CNT_W'(OQ_DEPTH - OQ_SLACK));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_top       <= '0;
            r_k_mid       <= '0;
            r_k_bot       <= '0;
            r_bias        <= '0;
            r_clamp_lo    <= CLAMP_LOW_RST;
            r_clamp_hi    <= CLAMP_HIGH_RST;
            r_image_width <= IMG_WIDTH_RST;
            r_col_cnt     <= '0;
            r_rows        <= ROWS_FIRST;
            r_flush_pend  <= 1'b0;
            r_fl_tag      <= '0;
            r_b_valid     <= 1'b0;
            r_b_item      <= 1'b0;
            r_b_tag       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_KERNEL_TOP: r_k_top       <= i_cfg_wdata;
                    CFG_KERNEL_MID: r_k_mid       <= i_cfg_wdata;
                    CFG_KERNEL_BOT: r_k_bot       <= i_cfg_wdata;
                    CFG_BIAS:       r_bias        <= i_cfg_wdata[OUT_W-1:0];
                    CFG_CLAMP_LOW:  r_clamp_lo    <= i_cfg_wdata[OUT_W-1:0];
                    CFG_CLAMP_HIGH: r_clamp_hi    <= i_cfg_wdata[OUT_W-1:0];
                    CFG_IMG_WIDTH:  r_image_width <= i_cfg_wdata[IMG_W_BITS-1:0];
                    default: ;
                endcase
            end
            r_b_valid    <= accept || r_flush_pend;
            r_flush_pend <= accept && is_last;
            if (accept) begin
                r_b_item            <= 1'b1;
                r_b_tag.valid       <= (r_rows != ROWS_FIRST) && (r_col_cnt != '0);
                r_b_tag.row_end     <= 1'b0;
                r_b_tag.image_end   <= 1'b0;
                r_b_tag.last_of_run <= !is_last;
                r_fl_tag.valid       <= (r_rows != ROWS_FIRST);
                r_fl_tag.row_end     <= 1'b1;
                r_fl_tag.image_end   <= pad;
                r_fl_tag.last_of_run <= 1'b1;
                if (is_last) begin
                    r_col_cnt <= '0;
                    if (pad) begin
                        r_rows <= ROWS_FIRST;
                    end else if (r_rows == ROWS_FIRST) begin
                        r_rows <= ROWS_SECOND;
                    end else begin
                        r_rows <= ROWS_LATER;
                    end
                end else begin
                    r_col_cnt <= r_col_cnt + CW'(1);
                end
            end else if (r_flush_pend) begin
                r_b_item <= 1'b0;
                r_b_tag  <= r_fl_tag;
            end else begin
                r_b_item <= 1'b0;
                r_b_tag  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_idx    <= r_col_cnt;
            r_b_pix    <= pix;
            r_b_rows   <= r_rows;
            r_rd_above <= line_above[r_col_cnt];
            r_rd_mid   <= line_middle[r_col_cnt];
        end
        if (r_b_valid && r_b_item) begin
            line_above[r_b_idx]  <= r_rd_mid;
            line_middle[r_b_idx] <= r_b_pix;
        end
    end

    always_comb begin
        newc[0] = (r_b_item && (r_b_rows >= ROWS_LATER))  ? r_rd_above : '0;
        newc[1] = (r_b_item && (r_b_rows >= ROWS_SECOND)) ? r_rd_mid   : '0;
        newc[2] = r_b_item ? r_b_pix : '0;
        wgt_l[0] = r_k_top[PIX_W-1:0];
        wgt_l[1] = r_k_mid[PIX_W-1:0];
        wgt_l[2] = r_k_bot[PIX_W-1:0];
        wgt_m[0] = r_k_top[2*PIX_W-1:PIX_W];
        wgt_m[1] = r_k_mid[2*PIX_W-1:PIX_W];
        wgt_m[2] = r_k_bot[2*PIX_W-1:PIX_W];
        wgt_r[0] = r_k_top[3*PIX_W-1:2*PIX_W];
        wgt_r[1] = r_k_mid[3*PIX_W-1:2*PIX_W];
        wgt_r[2] = r_k_bot[3*PIX_W-1:2*PIX_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_w <= '0;
            r_tag_p <= '0;
            r_tag_s <= '0;
        end else begin
            r_tag_w <= r_b_tag;
            r_tag_p <= r_tag_w;
            r_tag_s <= r_tag_p;
        end
    end

    dwc3_cell u_cell_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_b_valid),
        .i_col   (newc),
        .i_wgt   (wgt_r),
        .o_col   (col_r),
        .o_psum  (psum[2])
    );

    dwc3_cell u_cell_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_b_valid),
        .i_col   (col_r),
        .i_wgt   (wgt_m),
        .o_col   (col_m),
        .o_psum  (psum[1])
    );

    dwc3_cell u_cell_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_b_valid),
        .i_col   (col_m),
        .i_wgt   (wgt_l),
        .o_col   (),
        .o_psum  (psum[0])
    );

    dwc3_post u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psum     (psum),
        .i_tag      (r_tag_s),
        .i_bias     (r_bias),
        .i_clamp_lo (r_clamp_lo),
        .i_clamp_hi (r_clamp_hi),
        .o_push     (post_push),
        .o_item     (post_item)
    );

    dwc3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (post_push),
        .i_data  (post_item),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data),
        .o_count (oq_count)
    );

endmodule
